// ----- hdl/update_image_receive_session_top_defines.svh -----
// Assertion macros shared by the update image receive session modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef UPDATE_IMAGE_RECEIVE_SESSION_TOP_DEFINES_SVH
`define UPDATE_IMAGE_RECEIVE_SESSION_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define UIRS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define UIRS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/uirs_pkg.sv -----
// Shared types, codes and sizing constants for the update image receive session.
// Depends on nothing; used by all modules of the block.
package uirs_pkg;

    localparam int MaxPayload  = 256;
    localparam int StartLength = 20;
    localparam int SectorBytes = 4096;
    localparam int SectorCount = 32;
    localparam int SectorShift = $clog2(SectorBytes);
    localparam int QueueDepth  = 2;

    // Command codes.
    localparam logic [3:0] CMD_HELLO   = 4'd0;
    localparam logic [3:0] CMD_QUERY   = 4'd1;
    localparam logic [3:0] CMD_STATUS  = 4'd2;
    localparam logic [3:0] CMD_START   = 4'd3;
    localparam logic [3:0] CMD_DATA    = 4'd4;
    localparam logic [3:0] CMD_FINISH  = 4'd5;
    localparam logic [3:0] CMD_ABORT   = 4'd6;
    localparam logic [3:0] CMD_RESUME  = 4'd7;
    localparam logic [3:0] CMD_INSTALL = 4'd8;
    localparam logic [3:0] CMD_CONFIRM = 4'd9;

    // Response kinds.
    localparam logic [1:0] RSP_ACK  = 2'd0;
    localparam logic [1:0] RSP_NACK = 2'd1;
    localparam logic [1:0] RSP_INFO = 2'd2;

    // Status codes.
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_BAD_PACKET = 4'd1;
    localparam logic [3:0] ST_BAD_STATE  = 4'd2;
    localparam logic [3:0] ST_STORAGE    = 4'd3;
    localparam logic [3:0] ST_CONTAINER  = 4'd4;
    localparam logic [3:0] ST_TOO_LARGE  = 4'd5;
    localparam logic [3:0] ST_ID         = 4'd6;
    localparam logic [3:0] ST_SEQUENCE   = 4'd7;
    localparam logic [3:0] ST_OFFSET     = 4'd8;

    // Session phases.
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_RECEIVING = 2'd1;
    localparam logic [1:0] PH_FAILED    = 2'd2;
    localparam logic [1:0] PH_READY     = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_STORAGE_READY = 2'd0;
    localparam logic [1:0] CFG_IMAGE_TYPE    = 2'd1;
    localparam logic [1:0] CFG_FORMAT_VER    = 2'd2;
    localparam logic [1:0] CFG_CAPACITY      = 2'd3;

    // Classified request passed from the front to the back.
    typedef struct packed {
        logic        is_info;      // hello, query or status
        logic        is_start;
        logic        is_data;
        logic        is_finish;
        logic        is_abort;
        logic        is_resume;
        logic        is_unknown;   // codes ten and above
        logic        is_install;   // install or confirm
        logic        len_zero;
        logic        len_start;    // payload length equals start length
        logic        len_data_ok;  // payload length in one..max payload
        logic [3:0]  command;
        logic [31:0] session_id;
        logic [15:0] packet_sequence;
        logic [31:0] byte_offset;
        logic [15:0] payload_bytes;
        logic [7:0]  image_kind;
        logic [15:0] format_version;
        logic [31:0] announced_size;
        logic [31:0] announced_crc;
        logic [7:0]  flash_status;
        logic        replay_matches;
        logic [31:0] computed_crc;
        logic [31:0] sector_span;  // sector bits covered by the data range
    } req_t;

    // One response.
    typedef struct packed {
        logic [1:0]  response_kind;
        logic [3:0]  status_code;
        logic [31:0] error_detail;
        logic [1:0]  session_state_out;
        logic [31:0] active_id;
        logic [17:0] next_offset;
        logic [17:0] expected_total;
        logic        capable;
        logic [31:0] erase_request;
    } rsp_t;

endpackage

// ----- hdl/uirs_front.sv -----
// Front part: accepts requests, decodes the command and computes the sector span.
// Depends on uirs_pkg.
module uirs_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  uirs_pkg::req_t   in_raw,
    output logic             q_valid,
    input  logic             q_ready,
    output uirs_pkg::req_t   q_data
);

    logic           valid_reg;
    logic           valid_next;
    uirs_pkg::req_t data_reg;
    uirs_pkg::req_t cls;
    logic [32:0]    last_byte;
    logic [32:0]    first_sec;
    logic [32:0]    last_sec;

    assign in_ready = !valid_reg || q_ready;

    // Decode the command and precompute length checks and sector span.
    always_comb begin
        cls             = in_raw;
        cls.is_info     = (in_raw.command == uirs_pkg::CMD_HELLO) ||
                          (in_raw.command == uirs_pkg::CMD_QUERY) ||
                          (in_raw.command == uirs_pkg::CMD_STATUS);
        cls.is_start    = in_raw.command == uirs_pkg::CMD_START;
        cls.is_data     = in_raw.command == uirs_pkg::CMD_DATA;
        cls.is_finish   = in_raw.command == uirs_pkg::CMD_FINISH;
        cls.is_abort    = in_raw.command == uirs_pkg::CMD_ABORT;
        cls.is_resume   = in_raw.command == uirs_pkg::CMD_RESUME;
        cls.is_install  = (in_raw.command == uirs_pkg::CMD_INSTALL) ||
                          (in_raw.command == uirs_pkg::CMD_CONFIRM);
        cls.is_unknown  = in_raw.command > uirs_pkg::CMD_CONFIRM;
        cls.len_zero    = in_raw.payload_bytes == 16'd0;
        cls.len_start   = in_raw.payload_bytes == 16'(uirs_pkg::StartLength);
        cls.len_data_ok = (in_raw.payload_bytes != 16'd0) &&
                          (in_raw.payload_bytes <= 16'(uirs_pkg::MaxPayload));
        last_byte = {1'b0, in_raw.byte_offset} + {17'd0, in_raw.payload_bytes} - 33'd1;
        first_sec = {1'b0, in_raw.byte_offset} >> uirs_pkg::SectorShift;
        last_sec  = last_byte >> uirs_pkg::SectorShift;
        for (int s = 0; s < 32; s++) begin
            cls.sector_span[s] = (s < uirs_pkg::SectorCount) &&
                                 (33'(s) >= first_sec) && (33'(s) <= last_sec);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    // Control register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= cls;
        end
    end

    assign q_valid = valid_reg;
    assign q_data  = data_reg;

endmodule

// ----- hdl/uirs_queue.sv -----
// Short queue between the front and back parts of the session block.
// Depends on uirs_pkg.
module uirs_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  uirs_pkg::req_t   wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output uirs_pkg::req_t   rd_data
);

    localparam int PtrW = $clog2(uirs_pkg::QueueDepth);

    uirs_pkg::req_t       mem [uirs_pkg::QueueDepth];
    logic [PtrW-1:0]      wptr_reg, wptr_next;
    logic [PtrW-1:0]      rptr_reg, rptr_next;
    logic [PtrW:0]        count_reg, count_next;
    logic                 do_wr, do_rd;

    assign wr_ready = count_reg != (PtrW+1)'(uirs_pkg::QueueDepth);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and count updates.
    always_comb begin
        wptr_next  = do_wr ? PtrW'((wptr_reg + 1'b1) % uirs_pkg::QueueDepth) : wptr_reg;
        rptr_next  = do_rd ? PtrW'((rptr_reg + 1'b1) % uirs_pkg::QueueDepth) : rptr_reg;
        count_next = count_reg + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/uirs_back.sv -----
// Back part: checks each request against the session and updates the session.
// Depends on uirs_pkg and the assertion macros header.
`include "update_image_receive_session_top_defines.svh"
module uirs_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [17:0]      cfg_wdata,
    input  logic             q_valid,
    output logic             q_ready,
    input  uirs_pkg::req_t   q_data,
    output logic             out_valid,
    input  logic             out_ready,
    output uirs_pkg::rsp_t   out_data
);

    // Configuration.
    logic        storage_ready_reg;
    logic [7:0]  image_type_reg;
    logic [15:0] format_ver_reg;
    logic [17:0] capacity_reg;

    // Session state.
    logic [1:0]  phase_reg, phase_next;
    logic [31:0] current_id_reg, current_id_next;
    logic [17:0] total_size_reg, total_size_next;
    logic [17:0] received_reg, received_next;
    logic [31:0] target_crc_reg, target_crc_next;
    logic [31:0] erased_map_reg, erased_map_next;
    logic [15:0] wanted_seq_reg, wanted_seq_next;
    logic        replay_valid_reg, replay_valid_next;
    logic [17:0] replay_offset_reg, replay_offset_next;
    logic [15:0] replay_seq_reg, replay_seq_next;
    logic [8:0]  replay_len_reg, replay_len_next;

    logic           out_valid_reg, out_valid_next;
    uirs_pkg::rsp_t out_data_reg, rsp;
    logic           take;
    logic [1:0]     kind;
    logic [3:0]     status;
    logic [31:0]    detail;
    logic [31:0]    erase;
    logic [17:0]    remaining;
    logic           replay_hit;
    uirs_pkg::req_t r;

    assign q_ready = !out_valid_reg || out_ready;
    assign take    = q_valid && q_ready;
    assign r       = q_data;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            storage_ready_reg <= 1'b0;
            image_type_reg    <= 8'd0;
            format_ver_reg    <= 16'd1;
            capacity_reg      <= 18'd131072;
        end else if (cfg_we) begin
            unique case (cfg_index)
                uirs_pkg::CFG_STORAGE_READY: storage_ready_reg <= cfg_wdata[0];
                uirs_pkg::CFG_IMAGE_TYPE:    image_type_reg    <= cfg_wdata[7:0];
                uirs_pkg::CFG_FORMAT_VER:    format_ver_reg    <= cfg_wdata[15:0];
                uirs_pkg::CFG_CAPACITY:      capacity_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request checks and session update.
    always_comb begin
        phase_next         = phase_reg;
        current_id_next    = current_id_reg;
        total_size_next    = total_size_reg;
        received_next      = received_reg;
        target_crc_next    = target_crc_reg;
        erased_map_next    = erased_map_reg;
        wanted_seq_next    = wanted_seq_reg;
        replay_valid_next  = replay_valid_reg;
        replay_offset_next = replay_offset_reg;
        replay_seq_next    = replay_seq_reg;
        replay_len_next    = replay_len_reg;
        kind   = uirs_pkg::RSP_NACK;
        status = uirs_pkg::ST_BAD_PACKET;
        detail = 32'd0;
        erase  = 32'd0;
        remaining  = (total_size_reg > received_reg) ? total_size_reg - received_reg : 18'd0;
        replay_hit = replay_valid_reg && (r.packet_sequence == replay_seq_reg) &&
                     (r.byte_offset == {14'd0, replay_offset_reg}) &&
                     (r.payload_bytes == {7'd0, replay_len_reg});
        priority if (r.is_info) begin
            if (r.len_zero) begin
                kind   = uirs_pkg::RSP_INFO;
                status = uirs_pkg::ST_OK;
            end
        end else if (r.is_start) begin
            priority if (!r.len_start) begin
                status = uirs_pkg::ST_BAD_PACKET;
            end else if (phase_reg == uirs_pkg::PH_READY) begin
                status = uirs_pkg::ST_BAD_STATE;
            end else if (!storage_ready_reg) begin
                status = uirs_pkg::ST_STORAGE;
                detail = {24'd0, r.flash_status};
            end else if (r.session_id == 32'd0) begin
                status = uirs_pkg::ST_BAD_PACKET;
            end else if (r.image_kind != image_type_reg) begin
                status = uirs_pkg::ST_BAD_PACKET;
                detail = {24'd0, r.image_kind};
            end else if (r.format_version != format_ver_reg) begin
                status = uirs_pkg::ST_CONTAINER;
                detail = {16'd0, r.format_version};
            end else if ((r.announced_size == 32'd0) ||
                         (r.announced_size > {14'd0, capacity_reg})) begin
                status = uirs_pkg::ST_TOO_LARGE;
                detail = r.announced_size;
            end else begin
                kind              = uirs_pkg::RSP_ACK;
                status            = uirs_pkg::ST_OK;
                phase_next        = uirs_pkg::PH_RECEIVING;
                current_id_next   = r.session_id;
                total_size_next   = r.announced_size[17:0];
                received_next     = 18'd0;
                target_crc_next   = r.announced_crc;
                erased_map_next   = 32'd0;
                wanted_seq_next   = 16'd0;
                replay_valid_next = 1'b0;
            end
        end else if (r.is_data) begin
            priority if (phase_reg != uirs_pkg::PH_RECEIVING) begin
                status = uirs_pkg::ST_BAD_STATE;
            end else if (r.session_id != current_id_reg) begin
                status = uirs_pkg::ST_ID;
            end else if (!r.len_data_ok) begin
                status = uirs_pkg::ST_BAD_PACKET;
            end else if (replay_hit) begin
                if (r.replay_matches) begin
                    kind   = uirs_pkg::RSP_ACK;
                    status = uirs_pkg::ST_OK;
                end else begin
                    status = uirs_pkg::ST_OFFSET;
                    detail = r.byte_offset;
                end
            end else if (r.packet_sequence != wanted_seq_reg) begin
                status = uirs_pkg::ST_SEQUENCE;
                detail = {16'd0, wanted_seq_reg};
            end else if (r.byte_offset != {14'd0, received_reg}) begin
                status = uirs_pkg::ST_OFFSET;
                detail = {14'd0, received_reg};
            end else if ({2'd0, r.payload_bytes} > remaining) begin
                status = uirs_pkg::ST_OFFSET;
                detail = {14'd0, total_size_reg};
            end else if (r.flash_status != 8'd0) begin
                status = uirs_pkg::ST_STORAGE;
                detail = {24'd0, r.flash_status};
            end else begin
                kind               = uirs_pkg::RSP_ACK;
                status             = uirs_pkg::ST_OK;
                erase              = r.sector_span & ~erased_map_reg;
                erased_map_next    = erased_map_reg | r.sector_span;
                replay_valid_next  = 1'b1;
                replay_offset_next = r.byte_offset[17:0];
                replay_seq_next    = r.packet_sequence;
                replay_len_next    = r.payload_bytes[8:0];
                received_next      = received_reg + {2'd0, r.payload_bytes};
                wanted_seq_next    = wanted_seq_reg + 16'd1;
            end
        end else if (r.is_finish) begin
            priority if (!r.len_zero) begin
                status = uirs_pkg::ST_BAD_PACKET;
            end else if ((phase_reg == uirs_pkg::PH_READY) &&
                         (r.session_id == current_id_reg) &&
                         (received_reg == total_size_reg)) begin
                kind   = uirs_pkg::RSP_ACK;
                status = uirs_pkg::ST_OK;
            end else if (phase_reg != uirs_pkg::PH_RECEIVING) begin
                status = uirs_pkg::ST_BAD_STATE;
            end else if (r.session_id != current_id_reg) begin
                status = uirs_pkg::ST_ID;
            end else if (received_reg != total_size_reg) begin
                status = uirs_pkg::ST_OFFSET;
                detail = {14'd0, received_reg};
            end else if (r.flash_status != 8'd0) begin
                status = uirs_pkg::ST_STORAGE;
                detail = {24'd0, r.flash_status};
            end else if (r.computed_crc != target_crc_reg) begin
                status     = uirs_pkg::ST_CONTAINER;
                detail     = r.computed_crc;
                phase_next = uirs_pkg::PH_FAILED;
            end else begin
                kind       = uirs_pkg::RSP_ACK;
                status     = uirs_pkg::ST_OK;
                phase_next = uirs_pkg::PH_READY;
            end
        end else if (r.is_abort) begin
            if (r.len_zero) begin
                kind               = uirs_pkg::RSP_ACK;
                status             = uirs_pkg::ST_OK;
                phase_next         = uirs_pkg::PH_IDLE;
                current_id_next    = 32'd0;
                total_size_next    = 18'd0;
                received_next      = 18'd0;
                target_crc_next    = 32'd0;
                erased_map_next    = 32'd0;
                wanted_seq_next    = 16'd0;
                replay_valid_next  = 1'b0;
                replay_offset_next = 18'd0;
                replay_seq_next    = 16'd0;
                replay_len_next    = 9'd0;
            end
        end else if (r.is_resume) begin
            priority if (!r.len_zero) begin
                status = uirs_pkg::ST_BAD_PACKET;
            end else if (phase_reg != uirs_pkg::PH_RECEIVING) begin
                status = uirs_pkg::ST_BAD_STATE;
            end else if (r.session_id != current_id_reg) begin
                status = uirs_pkg::ST_ID;
            end else begin
                kind   = uirs_pkg::RSP_ACK;
                status = uirs_pkg::ST_OK;
            end
        end else if (r.is_install) begin
            status = uirs_pkg::ST_BAD_STATE;
        end else begin
            status = uirs_pkg::ST_BAD_PACKET;
            detail = {28'd0, r.command};
        end
        rsp.response_kind     = kind;
        rsp.status_code       = status;
        rsp.error_detail      = detail;
        rsp.session_state_out = phase_next;
        rsp.active_id         = current_id_next;
        rsp.next_offset       = received_next;
        rsp.expected_total    = total_size_next;
        rsp.capable           = storage_ready_reg;
        rsp.erase_request     = erase;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Session registers commit only when a request is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= uirs_pkg::PH_IDLE;
            current_id_reg    <= 32'd0;
            total_size_reg    <= 18'd0;
            received_reg      <= 18'd0;
            target_crc_reg    <= 32'd0;
            erased_map_reg    <= 32'd0;
            wanted_seq_reg    <= 16'd0;
            replay_valid_reg  <= 1'b0;
            replay_offset_reg <= 18'd0;
            replay_seq_reg    <= 16'd0;
            replay_len_reg    <= 9'd0;
            out_valid_reg     <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                phase_reg         <= phase_next;
                current_id_reg    <= current_id_next;
                total_size_reg    <= total_size_next;
                received_reg      <= received_next;
                target_crc_reg    <= target_crc_next;
                erased_map_reg    <= erased_map_next;
                wanted_seq_reg    <= wanted_seq_next;
                replay_valid_reg  <= replay_valid_next;
                replay_offset_reg <= replay_offset_next;
                replay_seq_reg    <= replay_seq_next;
                replay_len_reg    <= replay_len_next;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A pending response holds while the receiver stalls.
    `UIRS_ASSERT_NEXT(a_rsp_hold, aclk, aresetn, out_valid_reg && !out_ready,
        out_valid_reg && $stable(out_data_reg), "response changed while stalled")
    // Erase bits are only given on an acked data request.
    `UIRS_ASSERT_IMPL(a_erase_ack, aclk, aresetn, take && (erase != 32'd0),
        r.is_data && (kind == uirs_pkg::RSP_ACK), "erase outside data ack")
    // The erased map never loses bits on a data request.
    `UIRS_ASSERT_NEXT(a_map_grow, aclk, aresetn,
        take && r.is_data,
        (erased_map_reg & $past(erased_map_reg)) == $past(erased_map_reg),
        "erased map lost bits on data")

endmodule

// ----- hdl/update_image_receive_session_top.sv -----
// Top level of the update image receive session block.
// Depends on uirs_pkg, uirs_front, uirs_queue and uirs_back.
//
// Usage: one request per decoded command packet enters on the s_ channel
// (valid/ready) with the outcome of its flash work; exactly one response
// leaves on the m_ channel (valid/ready) carrying ack/nack/info, status,
// detail, the session fields after the request and the sector erase mask.
// A request passes the decode register, the two-entry queue and the
// response register. Throughput is one request per cycle while the
// receiver does not stall; the session check-and-update step in the back
// part is combinational. The user must write configuration registers
// through cfg_we/cfg_index/cfg_wdata only while the block is idle; the
// block does not enforce this. Reset clears the session to idle and the
// registers to their defaults. When the receiver stalls, the response
// register holds, the queue fills and then s_ready drops; nothing is lost.
module update_image_receive_session_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [17:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_command,
    input  logic [31:0] s_session_id,
    input  logic [15:0] s_packet_sequence,
    input  logic [31:0] s_byte_offset,
    input  logic [15:0] s_payload_bytes,
    input  logic [7:0]  s_image_kind,
    input  logic [15:0] s_format_version,
    input  logic [31:0] s_announced_size,
    input  logic [31:0] s_announced_crc,
    input  logic [7:0]  s_flash_status,
    input  logic        s_replay_matches,
    input  logic [31:0] s_computed_crc,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_response_kind,
    output logic [3:0]  m_status_code,
    output logic [31:0] m_error_detail,
    output logic [1:0]  m_session_state_out,
    output logic [31:0] m_active_id,
    output logic [17:0] m_next_offset,
    output logic [17:0] m_expected_total,
    output logic        m_capable,
    output logic [31:0] m_erase_request
);

    uirs_pkg::req_t raw, f_data, b_data;
    uirs_pkg::rsp_t rsp;
    logic           f_valid, f_ready, b_valid, b_ready;

    // Gather the request fields; the front fills in the decode.
    always_comb begin
        raw                 = '0;
        raw.command         = s_command;
        raw.session_id      = s_session_id;
        raw.packet_sequence = s_packet_sequence;
        raw.byte_offset     = s_byte_offset;
        raw.payload_bytes   = s_payload_bytes;
        raw.image_kind      = s_image_kind;
        raw.format_version  = s_format_version;
        raw.announced_size  = s_announced_size;
        raw.announced_crc   = s_announced_crc;
        raw.flash_status    = s_flash_status;
        raw.replay_matches  = s_replay_matches;
        raw.computed_crc    = s_computed_crc;
    end

    uirs_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_raw(raw),
        .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
    );

    uirs_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
    );

    uirs_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
        .out_valid(m_valid), .out_ready(m_ready), .out_data(rsp)
    );

    assign m_response_kind     = rsp.response_kind;
    assign m_status_code       = rsp.status_code;
    assign m_error_detail      = rsp.error_detail;
    assign m_session_state_out = rsp.session_state_out;
    assign m_active_id         = rsp.active_id;
    assign m_next_offset       = rsp.next_offset;
    assign m_expected_total    = rsp.expected_total;
    assign m_capable           = rsp.capable;
    assign m_erase_request     = rsp.erase_request;

endmodule
